/* sv/dasd_pkg.sv */
// Shared types, constants, microcode and calendar tables for the date add/subtract block.
`default_nettype none
package dasd_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int CYC_W      = 9;
  localparam int YEAR_MAX   = 9999;
  localparam int YEAR_CYCLE = 400;
  localparam int CENTURY    = 100;
  localparam int MONTHS     = 12;
  localparam int FEB_DAYS   = 28;
  localparam int MOD_STEPS  = 5;
  localparam int CNT_W      = 3;
  localparam int UPC_W      = 3;

  localparam logic [2:0] OP_NOP    = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;
  localparam logic [2:0] OP_INIT   = 3'd2;
  localparam logic [2:0] OP_MOD    = 3'd3;
  localparam logic [2:0] OP_BORROW = 3'd4;
  localparam logic [2:0] OP_CARRY  = 3'd5;
  localparam logic [2:0] OP_EMIT   = 3'd6;

  localparam logic [2:0] C_ALWAYS  = 3'd0;
  localparam logic [2:0] C_IN      = 3'd1;
  localparam logic [2:0] C_BAD     = 3'd2;
  localparam logic [2:0] C_CNT0    = 3'd3;
  localparam logic [2:0] C_DPOS    = 3'd4;
  localparam logic [2:0] C_DFIT    = 3'd5;
  localparam logic [2:0] C_OUTFREE = 3'd6;

  localparam logic [UPC_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [UPC_W-1:0] ST_INIT   = 3'd1;
  localparam logic [UPC_W-1:0] ST_MOD    = 3'd2;
  localparam logic [UPC_W-1:0] ST_BORROW = 3'd3;
  localparam logic [UPC_W-1:0] ST_CARRY  = 3'd4;
  localparam logic [UPC_W-1:0] ST_EMIT   = 3'd5;

  typedef struct packed {
    logic [2:0]       op;
    logic [2:0]       cond;
    logic [UPC_W-1:0] target;
    logic             hold;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic bad;
    logic cnt_zero;
    logic d_pos;
    logic d_fit;
  } flags_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               oor;
  } res_t;

  function automatic logic is_leap(input logic [CYC_W-1:0] ymod);
    return (ymod[1:0] == 2'd0) && (ymod != CYC_W'(CENTURY)) &&
           (ymod != CYC_W'(2 * CENTURY)) && (ymod != CYC_W'(3 * CENTURY));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd2:                     len = DAY_W'(FEB_DAYS) + DAY_W'(leap);
      4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // op, cond, target, hold
  function automatic ctrl_word_t ucode(input logic [UPC_W-1:0] upc);
    ctrl_word_t w;
    unique case (upc)
      ST_IDLE:   w = '{OP_LOAD,   C_IN,      ST_INIT,   1'b1};
      ST_INIT:   w = '{OP_INIT,   C_BAD,     ST_EMIT,   1'b0};
      ST_MOD:    w = '{OP_MOD,    C_CNT0,    ST_BORROW, 1'b1};
      ST_BORROW: w = '{OP_BORROW, C_DPOS,    ST_CARRY,  1'b1};
      ST_CARRY:  w = '{OP_CARRY,  C_DFIT,    ST_EMIT,   1'b1};
      ST_EMIT:   w = '{OP_EMIT,   C_OUTFREE, ST_IDLE,   1'b1};
      default:   w = '{OP_NOP,    C_ALWAYS,  ST_IDLE,   1'b0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* sv/dasd_seq.sv */
// Microcode sequencer: step counter, control store and conditional branch.
`default_nettype none
module dasd_seq (
  input  wire                  clk,
  input  wire                  rst,
  input  dasd_pkg::flags_t     flags,
  output dasd_pkg::ctrl_word_t ctrl
);

  logic [dasd_pkg::UPC_W-1:0] upc, upc_next;
  logic                       take;

  assign ctrl = dasd_pkg::ucode(upc);

  always_comb begin
    case (ctrl.cond)
      dasd_pkg::C_ALWAYS:  take = 1'b1;
      dasd_pkg::C_IN:      take = flags.in_valid;
      dasd_pkg::C_BAD:     take = flags.bad;
      dasd_pkg::C_CNT0:    take = flags.cnt_zero;
      dasd_pkg::C_DPOS:    take = flags.d_pos;
      dasd_pkg::C_DFIT:    take = flags.d_fit;
      dasd_pkg::C_OUTFREE: take = flags.out_free;
      default:             take = 1'b1;
    endcase
    if (take) begin
      upc_next = ctrl.target;
    end else if (ctrl.hold) begin
      upc_next = upc;
    end else begin
      upc_next = upc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= dasd_pkg::ST_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule
`default_nettype wire

/* sv/dasd_dp.sv */
// Datapath: date registers, year-cycle reduction and one-month normalize step.
`default_nettype none
module dasd_dp #(
  parameter int OFFSET_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  dasd_pkg::ctrl_word_t                ctrl,
  input  wire                                 in_take,
  input  wire                                 mode,
  input  wire [dasd_pkg::YEAR_W-1:0]          start_year,
  input  wire [dasd_pkg::MONTH_W-1:0]         start_month,
  input  wire [dasd_pkg::DAY_W-1:0]           start_day,
  input  wire [OFFSET_BITS-1:0]               day_offset,
  output logic                                bad_flag,
  output logic                                cnt_zero,
  output logic                                d_pos,
  output logic                                d_fit,
  output dasd_pkg::res_t                      res
);

  localparam int DW  = OFFSET_BITS + 2;
  localparam int YW  = dasd_pkg::YEAR_W;
  localparam int MW  = dasd_pkg::MONTH_W;
  localparam int DYW = dasd_pkg::DAY_W;
  localparam int CW  = dasd_pkg::CYC_W;

  logic [YW-1:0]              y, y0, ymod;
  logic [MW-1:0]              m, m0;
  logic [DYW-1:0]             d0;
  logic signed [DW-1:0]       d;
  logic [dasd_pkg::CNT_W-1:0] cnt;
  logic                       bad;

  logic signed [DW-1:0] d_start, dim_b_ext, dim_c_ext;
  logic [YW-1:0]        mod_sub, ymod_dec, ymod_inc;
  logic [MW-1:0]        m_b;
  logic [DYW-1:0]       dim_b, dim_c;
  logic                 wrap_b;

  always_comb begin
    d_start = mode ? (DW'(start_day) - DW'(day_offset)) : (DW'(start_day) + DW'(day_offset));
    mod_sub  = YW'(dasd_pkg::YEAR_CYCLE) << cnt;
    ymod_dec = (ymod[CW-1:0] == '0) ? YW'(dasd_pkg::YEAR_CYCLE - 1) : ymod - 1'b1;
    ymod_inc = (ymod[CW-1:0] == CW'(dasd_pkg::YEAR_CYCLE - 1)) ? '0 : ymod + 1'b1;
    wrap_b   = (m == MW'(1));
    m_b      = wrap_b ? MW'(dasd_pkg::MONTHS) : m - 1'b1;
    dim_b    = dasd_pkg::month_days(m_b,
                 dasd_pkg::is_leap(wrap_b ? ymod_dec[CW-1:0] : ymod[CW-1:0]));
    dim_c    = dasd_pkg::month_days(m, dasd_pkg::is_leap(ymod[CW-1:0]));
    dim_b_ext = DW'(dim_b);
    dim_c_ext = DW'(dim_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad <= 1'b0;
      cnt <= '0;
    end else begin
      unique case (ctrl.op)
        dasd_pkg::OP_LOAD: begin
          if (in_take) begin
            y   <= start_year;
            m   <= start_month;
            y0  <= start_year;
            m0  <= start_month;
            d0  <= start_day;
            d   <= d_start;
            bad <= (start_year == '0) || (start_year > YW'(dasd_pkg::YEAR_MAX)) ||
                   (start_month == '0) || (start_month > MW'(dasd_pkg::MONTHS));
          end
        end
        dasd_pkg::OP_INIT: begin
          cnt  <= dasd_pkg::CNT_W'(dasd_pkg::MOD_STEPS - 1);
          ymod <= y;
        end
        dasd_pkg::OP_MOD: begin
          if (ymod >= mod_sub) begin
            ymod <= ymod - mod_sub;
          end
          cnt <= cnt - 1'b1;
        end
        dasd_pkg::OP_BORROW: begin
          if (!bad && d <= 0) begin
            if (wrap_b && y == YW'(1)) begin
              bad <= 1'b1;
            end else begin
              m <= m_b;
              d <= d + dim_b_ext;
              if (wrap_b) begin
                y    <= y - 1'b1;
                ymod <= ymod_dec;
              end
            end
          end
        end
        dasd_pkg::OP_CARRY: begin
          if (!bad && d > dim_c_ext) begin
            if (m == MW'(dasd_pkg::MONTHS)) begin
              if (y == YW'(dasd_pkg::YEAR_MAX)) begin
                bad <= 1'b1;
              end else begin
                d    <= d - dim_c_ext;
                m    <= MW'(1);
                y    <= y + 1'b1;
                ymod <= ymod_inc;
              end
            end else begin
              d <= d - dim_c_ext;
              m <= m + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign bad_flag = bad;
  assign cnt_zero = (cnt == '0);
  assign d_pos    = bad || (d > 0);
  assign d_fit    = bad || (d <= dim_c_ext);

  always_comb begin
    res.oor   = bad;
    res.year  = bad ? y0 : y;
    res.month = bad ? m0 : m;
    res.day   = bad ? d0 : d[DYW-1:0];
  end

endmodule
`default_nettype wire

/* sv/date_add_subtract_days.sv */
// Top level: handshakes, result register and the sequencer/datapath pair.
`default_nettype none
// Gregorian date plus or minus a day count. One beat at a time: after a beat
// is taken, in_stall stays high until its result is loaded into the output
// register. A taken beat passes through the init step, the reduction of the
// year modulo 400 for the leap rule, the borrow loop, the carry loop and the
// emit step; the next beat can be taken once the sequencer is back in idle.
// The emit step waits until the output register is free. One month is
// normalized per cycle by the microcoded loop. A bad input date skips the
// reduction and the loop: it goes from the init step straight to emit.
// An input year outside 1..9999 or month outside 1..12, or a year leaving
// 1..9999, sets out_of_range and echoes the input.
// The result register frees the datapath, so the next beat can be taken
// while a result still waits on out_stall.
module date_add_subtract_days #(
  parameter int OFFSET_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 in_valid,
  output logic                                in_stall,
  input  wire                                 mode,
  input  wire [dasd_pkg::YEAR_W-1:0]          start_year,
  input  wire [dasd_pkg::MONTH_W-1:0]         start_month,
  input  wire [dasd_pkg::DAY_W-1:0]           start_day,
  input  wire [OFFSET_BITS-1:0]               day_offset,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [dasd_pkg::YEAR_W-1:0]         result_year,
  output logic [dasd_pkg::MONTH_W-1:0]        result_month,
  output logic [dasd_pkg::DAY_W-1:0]          result_day,
  output logic                                out_of_range
);

  dasd_pkg::ctrl_word_t ctrl;
  dasd_pkg::flags_t     flags;
  dasd_pkg::res_t       res;
  logic                 in_take, emit, out_free;
  logic                 bad_flag, cnt_zero, d_pos, d_fit;

  assign in_stall = rst || (ctrl.op != dasd_pkg::OP_LOAD);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign emit     = (ctrl.op == dasd_pkg::OP_EMIT) && out_free;

  always_comb begin
    flags.in_valid = in_valid;
    flags.out_free = out_free;
    flags.bad      = bad_flag;
    flags.cnt_zero = cnt_zero;
    flags.d_pos    = d_pos;
    flags.d_fit    = d_fit;
  end

  dasd_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  dasd_dp #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .in_take     (in_take),
    .mode        (mode),
    .start_year  (start_year),
    .start_month (start_month),
    .start_day   (start_day),
    .day_offset  (day_offset),
    .bad_flag    (bad_flag),
    .cnt_zero    (cnt_zero),
    .d_pos       (d_pos),
    .d_fit       (d_fit),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_year  <= res.year;
      result_month <= res.month;
      result_day   <= res.day;
      out_of_range <= res.oor;
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_take |=> in_stall)
    else $error("block not busy after taking a beat");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (rst)
    emit |=> !in_stall)
    else $error("block not ready after emitting a result");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(emit))
    else $error("result appeared without an emit step");

  a_result_sane: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_of_range) |->
      (result_month >= 4'd1 && result_month <= 4'd12 && result_day != 5'd0 &&
       result_year != '0 && result_year <= 14'd9999))
    else $error("normalized result date out of range");

endmodule
`default_nettype wire

/* tb/date_check_pkg.sv */
// Scoreboard class for the date add/subtract block: date arithmetic and result compare.
package date_check_pkg;
  import dasd_pkg::*;

  localparam int OFFSET_W = 16;

  class date_scoreboard;
    res_t pending_dates[$];
    int   mismatch_count = 0;

    function int month_length(int year, int month);
      int len;
      case (month)
        2:             len = FEB_DAYS;
        4, 6, 9, 11:   len = 30;
        default:       len = 31;
      endcase
      if (month == 2 &&
          ((year % 4 == 0 && year % CENTURY != 0) || year % YEAR_CYCLE == 0))
        len += 1;
      return len;
    endfunction

    function res_t shifted_date(bit sub, logic [YEAR_W-1:0] y0, logic [MONTH_W-1:0] m0,
                                logic [DAY_W-1:0] d0, logic [OFFSET_W-1:0] off);
      res_t r;
      int   y;
      int   m;
      int   d;
      bit   bad;
      y   = int'(y0);
      m   = int'(m0);
      bad = (y < 1) || (y > YEAR_MAX) || (m < 1) || (m > MONTHS);
      d   = sub ? int'(d0) - int'(off) : int'(d0) + int'(off);
      while (!bad && d <= 0) begin
        m -= 1;
        if (m < 1) begin
          m = MONTHS;
          y -= 1;
          if (y < 1) bad = 1'b1;
        end
        if (!bad) d += month_length(y, m);
      end
      while (!bad && d > month_length(y, m)) begin
        d -= month_length(y, m);
        m += 1;
        if (m > MONTHS) begin
          m = 1;
          y += 1;
          if (y > YEAR_MAX) bad = 1'b1;
        end
      end
      if (bad) begin
        r.year  = y0;
        r.month = m0;
        r.day   = d0;
        r.oor   = 1'b1;
      end else begin
        r.year  = YEAR_W'(y);
        r.month = MONTH_W'(m);
        r.day   = DAY_W'(d);
        r.oor   = 1'b0;
      end
      return r;
    endfunction

    function void note_request(bit sub, logic [YEAR_W-1:0] y0, logic [MONTH_W-1:0] m0,
                               logic [DAY_W-1:0] d0, logic [OFFSET_W-1:0] off);
      pending_dates.push_back(shifted_date(sub, y0, m0, d0, off));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_dates.size() == 0) begin
        $error("result beat with no request pending");
        mismatch_count++;
        return;
      end
      want = pending_dates.pop_front();
      if (got.year !== want.year) begin
        $error("result_year: expected %0d, got %0d", want.year, got.year);
        mismatch_count++;
      end
      if (got.month !== want.month) begin
        $error("result_month: expected %0d, got %0d", want.month, got.month);
        mismatch_count++;
      end
      if (got.day !== want.day) begin
        $error("result_day: expected %0d, got %0d", want.day, got.day);
        mismatch_count++;
      end
      if (got.oor !== want.oor) begin
        $error("out_of_range: expected %0d, got %0d", want.oor, got.oor);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return pending_dates.size();
    endfunction
  endclass

endpackage

/* tb/date_add_subtract_days_test.sv */
// Testbench top: drives date/offset beats with random gaps and checks every result.
module date_add_subtract_days_test;
  timeunit 1ns;
  timeprecision 1ps;
  import dasd_pkg::*;
  import date_check_pkg::*;

  localparam bit MODE_ADD     = 1'b0;
  localparam bit MODE_SUB     = 1'b1;
  localparam int RANDOM_BEATS = 250;
  localparam int HOLD_CYCLES  = 3000;
  localparam int HOLD_AT_BEAT = 40;
  localparam int LIMIT        = 2000000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                mode = MODE_ADD;
  logic [YEAR_W-1:0]   start_year = '0;
  logic [MONTH_W-1:0]  start_month = '0;
  logic [DAY_W-1:0]    start_day = '0;
  logic [OFFSET_W-1:0] day_offset = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [YEAR_W-1:0]   result_year;
  logic [MONTH_W-1:0]  result_month;
  logic [DAY_W-1:0]    result_day;
  logic                out_of_range;

  int             cycle_count = 0;
  int             sent = 0;
  date_scoreboard sb = new();

  date_add_subtract_days #(.OFFSET_BITS(OFFSET_W)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .day_offset   (day_offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day),
    .out_of_range (out_of_range)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic send_beat(input bit sub, input int y, input int m, input int d,
                           input int off);
    int gap;
    gap = ((sent / 25) % 4 == 3) ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode        = sub;
    start_year  = YEAR_W'(y);
    start_month = MONTH_W'(m);
    start_day   = DAY_W'(d);
    day_offset  = OFFSET_W'(off);
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(mode, start_year, start_month, start_day, day_offset);
    sent++;
  endtask

  task automatic send_random();
    int y;
    int m;
    int d;
    int off;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // noise: any encodable field value
      y = $urandom_range(0, (1 << YEAR_W) - 1);
      m = $urandom_range(0, (1 << MONTH_W) - 1);
      d = $urandom_range(0, (1 << DAY_W) - 1);
    end else begin
      if (pick < 18)      y = $urandom_range(1, 3);
      else if (pick < 26) y = $urandom_range(YEAR_MAX - 2, YEAR_MAX);
      else                y = $urandom_range(1, YEAR_MAX);
      m = $urandom_range(1, MONTHS);
      d = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 31) : $urandom_range(1, FEB_DAYS);
    end
    pick = $urandom_range(0, 99);
    if (pick < 55)      off = $urandom_range(0, 400);
    else if (pick < 80) off = $urandom_range(0, 5000);
    else if (pick < 92) off = $urandom_range(0, (1 << OFFSET_W) - 1);
    else                off = (1 << OFFSET_W) - 1 - $urandom_range(0, 300);
    send_beat($urandom_range(0, 1) ? MODE_SUB : MODE_ADD, y, m, d, off);
  endtask

  // result side
  initial begin
    int   gap;
    int   taken;
    res_t got;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken == HOLD_AT_BEAT) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = ((taken / 20) % 4 == 2) ? 0 : $urandom_range(0, 12);
      if (gap == 0) begin
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b1;
        do @(posedge clk); while (!out_valid);
        @(negedge clk);
        repeat (gap - 1) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      got.year  = result_year;
      got.month = result_month;
      got.day   = result_day;
      got.oor   = out_of_range;
      sb.check_result(got);
      taken++;
      @(negedge clk);
    end
  end

  initial begin
    while (cycle_count < LIMIT) @(posedge clk);
    $display("date_add_subtract_days_test NOT OK");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_beat(MODE_ADD, 2024, 2, 29, 0);
    send_beat(MODE_ADD, 2023, 2, 30, 0);
    send_beat(MODE_ADD, 2024, 2, 30, 0);
    send_beat(MODE_ADD, 2023, 4, 31, 0);
    send_beat(MODE_SUB, 2023, 3, 0, 0);
    send_beat(MODE_ADD, 1900, 2, 28, 1);
    send_beat(MODE_ADD, 2000, 2, 28, 1);
    send_beat(MODE_ADD, 2100, 2, 28, 1);
    send_beat(MODE_SUB, 2400, 3, 1, 1);
    send_beat(MODE_ADD, 1999, 12, 31, 1);
    send_beat(MODE_SUB, 2001, 1, 31, 31);
    send_beat(MODE_ADD, YEAR_MAX, 12, 31, 0);
    send_beat(MODE_ADD, YEAR_MAX, 12, 31, 1);
    send_beat(MODE_SUB, 1, 1, 1, 0);
    send_beat(MODE_SUB, 1, 1, 1, 1);
    send_beat(MODE_ADD, 1, 1, 0, 0);
    send_beat(MODE_ADD, 0, 6, 15, 10);
    send_beat(MODE_ADD, (1 << YEAR_W) - 1, 15, 31, (1 << OFFSET_W) - 1);
    send_beat(MODE_ADD, 2020, 0, 10, 5);
    send_beat(MODE_SUB, 2020, 13, 10, 5);
    send_beat(MODE_ADD, 2000, 1, 1, (1 << OFFSET_W) - 1);
    send_beat(MODE_SUB, 5000, 6, 15, (1 << OFFSET_W) - 1);
    send_beat(MODE_SUB, 100, 3, 1, (1 << OFFSET_W) - 1);
    send_beat(MODE_ADD, 9900, 1, 1, (1 << OFFSET_W) - 1);

    for (int i = 0; i < RANDOM_BEATS; i++) send_random();
    @(negedge clk);
    in_valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatch_count == 0)
      $display("date_add_subtract_days_test OK");
    else
      $display("date_add_subtract_days_test NOT OK");
    $finish;
  end

endmodule
